// ===== hw/rtl/pmc_pkg.sv =====
// pmc_pkg: payload structs, codes, reset values and the duty digit split
// for the PWM motor command controller. No dependencies.
package pmc_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_BYTE = 2'd1,
    OP_KEY  = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KEY_UP   = 2'd0,
    KEY_DOWN = 2'd1,
    KEY_FWD  = 2'd2,
    KEY_REV  = 2'd3
  } key_t;

  localparam logic [7:0] CMD_UP      = 8'h06;
  localparam logic [7:0] CMD_DOWN    = 8'h04;
  localparam logic [7:0] CMD_FWD     = 8'h0F;
  localparam logic [7:0] CMD_REV     = 8'h05;
  localparam logic [7:0] CMD_LEFT    = 8'h09;
  localparam logic [7:0] CMD_RIGHT   = 8'h0A;
  localparam logic [7:0] CMD_STOP    = 8'h0B;

  localparam logic [1:0] REG_DUTY_STEP  = 2'd0;
  localparam logic [1:0] REG_DUTY_MAX   = 2'd1;
  localparam logic [1:0] REG_PWM_PERIOD = 2'd2;

  localparam logic [3:0] BRIDGE_FWD     = 4'b1010;
  localparam logic [3:0] BRIDGE_REV     = 4'b0101;
  localparam logic [3:0] BRIDGE_LEFT_F  = 4'b1000;
  localparam logic [3:0] BRIDGE_LEFT_R  = 4'b0100;
  localparam logic [3:0] BRIDGE_RIGHT_F = 4'b0010;
  localparam logic [3:0] BRIDGE_RIGHT_R = 4'b0001;
  localparam logic [3:0] BRIDGE_OFF     = 4'b0000;

  localparam logic [6:0] DUTY_RESET       = 7'd20;
  localparam logic [6:0] DUTY_STEP_RESET  = 7'd10;
  localparam logic [6:0] DUTY_MAX_RESET   = 7'd100;
  localparam logic [6:0] PERIOD_RESET     = 7'd100;
  localparam logic [6:0] HUNDRED          = 7'd100;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [1:0] key_code;
  } in_t;

  typedef struct packed {
    logic       pwm_level;
    logic       left_fwd;
    logic       left_rev;
    logic       right_fwd;
    logic       right_rev;
    logic [6:0] duty_now;
    logic       digit_hundreds;
    logic [3:0] digit_tens;
    logic [3:0] digit_ones;
  } out_t;

  typedef struct packed {
    logic [6:0] duty_step;
    logic [6:0] duty_max;
    logic [6:0] pwm_period;
  } cfg_t;

  typedef struct packed {
    logic [6:0] duty;
    logic [6:0] phase;
    logic [3:0] bridge;
    logic       level;
  } state_t;

  typedef struct packed {
    logic       hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  // tens by reciprocal: x * 205 >> 11 is exact for x below 100
  function automatic digits_t split_digits(input logic [6:0] value);
    digits_t    d;
    logic [6:0] rem;
    logic [14:0] prod;
    logic [6:0] tens_x10;
    d.hundreds = (value >= HUNDRED);
    rem        = d.hundreds ? (value - HUNDRED) : value;
    prod       = 15'(rem) * 15'd205;
    d.tens     = prod[14:11];
    tens_x10   = 7'(d.tens) * 7'd10;
    d.ones     = 4'(rem - tens_x10);
    return d;
  endfunction

endpackage

// ===== hw/rtl/pmc_core.sv =====
// pmc_core: next-state and result logic for one beat of the controller.
// Purely combinational; depends on pmc_pkg.
module pmc_core #(
  parameter int FRAME_BYTES = 3,
  parameter int POS_W       = 2
) (
  input  pmc_pkg::in_t    item,
  input  pmc_pkg::cfg_t   cfg,
  input  pmc_pkg::state_t cur,
  input  logic [POS_W-1:0] pos,
  output pmc_pkg::state_t nxt,
  output logic [POS_W-1:0] pos_nxt,
  output pmc_pkg::out_t   result
);

  logic [7:0]          up_sum;
  logic [6:0]          duty_up;
  logic [6:0]          duty_down;
  logic [6:0]          phase_inc;
  pmc_pkg::digits_t    dig;

  assign up_sum    = {1'b0, cur.duty} + {1'b0, cfg.duty_step};
  assign duty_up   = (up_sum >= {1'b0, cfg.duty_max}) ? cfg.duty_max : up_sum[6:0];
  assign duty_down = (cur.duty <= cfg.duty_step) ? 7'd0 : (cur.duty - cfg.duty_step);
  assign phase_inc = cur.phase + 7'd1;

  always_comb begin
    nxt     = cur;
    pos_nxt = pos;
    case (item.opcode)
      pmc_pkg::OP_TICK: begin
        nxt.level = (cur.duty > phase_inc);
        nxt.phase = (phase_inc >= cfg.pwm_period) ? 7'd0 : phase_inc;
      end
      pmc_pkg::OP_BYTE: begin
        if (pos == POS_W'(FRAME_BYTES - 1)) begin
          pos_nxt = '0;
          case (item.data_byte)
            pmc_pkg::CMD_UP:    nxt.duty   = duty_up;
            pmc_pkg::CMD_DOWN:  nxt.duty   = duty_down;
            pmc_pkg::CMD_FWD:   nxt.bridge = pmc_pkg::BRIDGE_FWD;
            pmc_pkg::CMD_REV:   nxt.bridge = pmc_pkg::BRIDGE_REV;
            pmc_pkg::CMD_LEFT:  nxt.bridge = cur.bridge[1] ? pmc_pkg::BRIDGE_LEFT_F
                                                           : pmc_pkg::BRIDGE_LEFT_R;
            pmc_pkg::CMD_RIGHT: nxt.bridge = cur.bridge[3] ? pmc_pkg::BRIDGE_RIGHT_F
                                                           : pmc_pkg::BRIDGE_RIGHT_R;
            pmc_pkg::CMD_STOP:  nxt.bridge = pmc_pkg::BRIDGE_OFF;
            default: ;
          endcase
        end else begin
          pos_nxt = pos + POS_W'(1);
        end
      end
      pmc_pkg::OP_KEY: begin
        case (item.key_code)
          pmc_pkg::KEY_UP:   nxt.duty   = duty_up;
          pmc_pkg::KEY_DOWN: nxt.duty   = duty_down;
          pmc_pkg::KEY_FWD:  nxt.bridge = pmc_pkg::BRIDGE_FWD;
          default:           nxt.bridge = pmc_pkg::BRIDGE_REV;
        endcase
      end
      default: ;
    endcase
  end

  assign dig = pmc_pkg::split_digits(nxt.duty);

  always_comb begin
    result.pwm_level      = nxt.level;
    result.left_fwd       = nxt.bridge[3];
    result.left_rev       = nxt.bridge[2];
    result.right_fwd      = nxt.bridge[1];
    result.right_rev      = nxt.bridge[0];
    result.duty_now       = nxt.duty;
    result.digit_hundreds = dig.hundreds;
    result.digit_tens     = dig.tens;
    result.digit_ones     = dig.ones;
  end

endmodule

// ===== hw/rtl/pwm_motor_command_controller.sv =====
// pwm_motor_command_controller: top level with state, configuration and
// result registers around pmc_core. Depends on pmc_pkg and pmc_core.
//
//   channel | ports                          | beat
//   in      | in_valid, in_ready, in_data    | tick, serial byte, key press or nop
//   out     | out_valid, out_ready, out_data | levels, bridge bits, duty, digits
//   cfg     | cfg_we, cfg_idx, cfg_wdata     | one register write, no wait
//
// One beat a cycle while out_ready does not stall: each accepted item updates
// state and loads the result register, whose result appears the next cycle.
// in_ready is high while the result register is empty or being drained.
// Synchronous active-low reset restores duty 20, phase 0, forward bridge.
// A stalled out_ready holds the result and blocks the next input beat.
module pwm_motor_command_controller #(
  parameter int FRAME_BYTES = 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pmc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pmc_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_idx,
  input  logic [6:0]     cfg_wdata
);

  localparam int POS_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  pmc_pkg::cfg_t    cfg_r;
  pmc_pkg::state_t  state_r;
  pmc_pkg::state_t  state_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  pmc_pkg::out_t    out_r;
  pmc_pkg::out_t    out_nxt;
  logic             out_valid_r;
  logic             accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  pmc_core #(
    .FRAME_BYTES (FRAME_BYTES),
    .POS_W       (POS_W)
  ) u_core (
    .item    (in_data),
    .cfg     (cfg_r),
    .cur     (state_r),
    .pos     (pos_r),
    .nxt     (state_nxt),
    .pos_nxt (pos_nxt),
    .result  (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_step  <= pmc_pkg::DUTY_STEP_RESET;
      cfg_r.duty_max   <= pmc_pkg::DUTY_MAX_RESET;
      cfg_r.pwm_period <= pmc_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        pmc_pkg::REG_DUTY_STEP:  cfg_r.duty_step  <= cfg_wdata;
        pmc_pkg::REG_DUTY_MAX:   cfg_r.duty_max   <= cfg_wdata;
        pmc_pkg::REG_PWM_PERIOD: cfg_r.pwm_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.duty   <= pmc_pkg::DUTY_RESET;
      state_r.phase  <= '0;
      state_r.bridge <= pmc_pkg::BRIDGE_FWD;
      state_r.level  <= 1'b0;
      pos_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        pos_r       <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !(out_valid_r && !out_ready))
    else $error("input beat taken while result stalled");

  a_bridge_safe: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.bridge[3] && state_r.bridge[2]) && !(state_r.bridge[1] && state_r.bridge[0]))
    else $error("both drive bits of one bridge high");

  a_duty_held: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(state_r.duty))
    else $error("duty changed without an input beat");

  a_result_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.duty_now == state_r.duty))
    else $error("result duty differs from state");

  a_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((8'(out_r.digit_hundreds) * 8'd100 + 8'(out_r.digit_tens) * 8'd10
                      + 8'(out_r.digit_ones)) == 8'(out_r.duty_now)))
    else $error("decimal digits do not match duty");

endmodule
